/* rtl/core/bpa_pkg.sv */
package bpa_pkg;

  localparam int PAGES      = 1024;
  localparam int MAP_WORDS  = PAGES / 32;
  localparam int WORD_AW    = $clog2(MAP_WORDS);
  localparam int IDX_W      = $clog2(PAGES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_PAY_W  = IDX_W + ADDR_W + CNT_W + CNT_W + 1;
  localparam int OUT_DATA_W = ((OUT_PAY_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_MEM     = 2'd1,
    ST_OUT_REGION = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE      = 2'd0,
    CFG_RESERVED  = 2'd1,
    CFG_THRESHOLD = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WRITE
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] base_address;
    logic [CNT_W-1:0]  reserved_pages;
    logic [CNT_W-1:0]  grow_threshold;
  } bpa_cfg_t;

  typedef struct packed {
    status_e           status;
    logic [IDX_W-1:0]  page_num;
    logic [ADDR_W-1:0] alloc_address;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  high_water;
    logic              grow_request;
  } bpa_result_t;

  // Position of the lowest clear bit; zero when the word is full.
  function automatic logic [4:0] first_zero(input logic [31:0] word);
    logic [4:0] pos;
    pos = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (!word[i]) begin
        pos = 5'(i);
      end
    end
    return pos;
  endfunction

  // Contents of map word w right after a clear that reserved r pages.
  function automatic logic [31:0] clear_word(input logic [CNT_W-1:0] r,
                                             input logic [WORD_AW-1:0] w);
    logic [CNT_W:0] lo;
    logic [CNT_W:0] diff;
    logic [31:0]    res;
    lo   = {2'b0, w, 5'b0};
    diff = {1'b0, r} - lo;
    if ({1'b0, r} >= lo + (CNT_W+1)'(32)) begin
      res = '1;
    end else if ({1'b0, r} <= lo) begin
      res = '0;
    end else begin
      res = ~({32{1'b1}} << diff[4:0]);
    end
    return res;
  endfunction

endpackage

/* rtl/core/bpa_map_ram.sv */
module bpa_map_ram
  import bpa_pkg::*;
(
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [WORD_AW-1:0] waddr_i,
  input  logic [31:0]        wdata_i,
  input  logic               re_i,
  input  logic [WORD_AW-1:0] raddr_i,
  output logic [31:0]        rdata_o
);

  logic [31:0] mem [MAP_WORDS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* rtl/core/bpa_ctrl.sv */
module bpa_ctrl
  import bpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bpa_cfg_t          cfg_i,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic [1:0]        req_opcode_i,
  input  logic [ADDR_W-1:0] req_address_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output bpa_result_t       res_o
);

  localparam logic [ADDR_W:0] REGION_SPAN = (ADDR_W+1)'(PAGES - 1) << PAGE_SHIFT;

  state_e state_q, state_d;

  logic [MAP_WORDS-1:0] full_q;
  logic [MAP_WORDS-1:0] row_valid_q;
  logic [CNT_W-1:0]     clr_r_q;
  logic [CNT_W-1:0]     free_q;
  logic [CNT_W-1:0]     hwm_q;

  op_e                  op_q;
  logic [WORD_AW-1:0]   word_q;
  logic [4:0]           bit_q;
  logic                 hit_q;

  logic                 accept;
  logic                 fire;
  logic                 ram_re;
  logic                 ram_we;
  logic [31:0]          ram_rdata;

  // Decode at accept time.
  logic [WORD_AW-1:0]   alloc_word;
  logic                 alloc_any;
  logic [ADDR_W-1:0]    aligned;
  logic [ADDR_W-1:0]    offset;
  logic                 in_region;
  logic [IDX_W-1:0]     free_idx;

  // Modify stage.
  logic [31:0]          cur_word;
  logic [31:0]          new_word;
  logic [4:0]           alloc_bit;
  logic [31:0]          free_mask;
  logic                 was_used;
  logic [IDX_W-1:0]     alloc_idx;
  logic [CNT_W-1:0]     alloc_idx1;
  logic [CNT_W-1:0]     hwm_alloc;
  logic [CNT_W-1:0]     rsv_sat;

  assign accept = req_valid_i && req_ready_o;
  assign fire   = res_valid_o && res_ready_i;

  always_comb begin
    alloc_word = '0;
    alloc_any  = 1'b0;
    for (int i = MAP_WORDS - 1; i >= 0; i--) begin
      if (!full_q[i]) begin
        alloc_word = WORD_AW'(i);
        alloc_any  = 1'b1;
      end
    end
  end

  assign aligned   = {req_address_i[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
  assign offset    = aligned - cfg_i.base_address;
  assign in_region = (aligned >= cfg_i.base_address) &&
                     ({1'b0, aligned} <= ({1'b0, cfg_i.base_address} + REGION_SPAN));
  assign free_idx  = offset[PAGE_SHIFT +: IDX_W];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_READ;
      S_READ:  state_d = S_WRITE;
      S_WRITE: if (fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o = 1'b0;
    ram_re      = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE:  req_ready_o = 1'b1;
      S_READ:  ram_re      = 1'b1;
      S_WRITE: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_e'(req_opcode_i);
      if (op_e'(req_opcode_i) == OP_FREE) begin
        word_q <= free_idx[IDX_W-1:5];
        bit_q  <= free_idx[4:0];
        hit_q  <= in_region;
      end else begin
        word_q <= alloc_word;
        bit_q  <= '0;
        hit_q  <= alloc_any;
      end
    end
  end

  bpa_map_ram u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (word_q),
    .wdata_i (new_word),
    .re_i    (ram_re),
    .raddr_i (word_q),
    .rdata_o (ram_rdata)
  );

  // A row not written since the last clear still holds the clear pattern.
  assign cur_word   = row_valid_q[word_q] ? ram_rdata : clear_word(clr_r_q, word_q);
  assign alloc_bit  = first_zero(cur_word);
  assign free_mask  = 32'(1) << bit_q;
  assign was_used   = |(cur_word & free_mask);
  assign alloc_idx  = {word_q, alloc_bit};
  assign alloc_idx1 = {1'b0, alloc_idx} + CNT_W'(1);
  assign hwm_alloc  = (alloc_idx1 >= hwm_q) ? alloc_idx1 : hwm_q;
  assign rsv_sat    = (cfg_i.reserved_pages > CNT_W'(PAGES)) ? CNT_W'(PAGES)
                                                             : cfg_i.reserved_pages;

  always_comb begin
    new_word = cur_word;
    ram_we   = 1'b0;
    case (op_q)
      OP_ALLOC: begin
        new_word = cur_word | (32'(1) << alloc_bit);
        ram_we   = fire && hit_q;
      end
      OP_FREE: begin
        new_word = cur_word & ~free_mask;
        ram_we   = fire && hit_q && was_used;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o               = '0;
    res_o.status        = ST_OK;
    res_o.free_count    = free_q;
    res_o.high_water    = hwm_q;
    case (op_q)
      OP_ALLOC: begin
        if (hit_q) begin
          res_o.page_num      = alloc_idx;
          res_o.alloc_address = cfg_i.base_address + (ADDR_W'(alloc_idx) << PAGE_SHIFT);
          res_o.free_count    = (free_q != '0) ? free_q - CNT_W'(1) : free_q;
          res_o.high_water    = hwm_alloc;
          res_o.grow_request  = (hwm_alloc == cfg_i.grow_threshold);
        end else begin
          res_o.status = ST_NO_MEM;
        end
      end
      OP_FREE: begin
        if (hit_q) begin
          res_o.page_num = {word_q, bit_q};
          if (was_used && (free_q < CNT_W'(PAGES))) begin
            res_o.free_count = free_q + CNT_W'(1);
          end
        end else begin
          res_o.status = ST_OUT_REGION;
        end
      end
      OP_CLEAR: begin
        res_o.free_count = CNT_W'(PAGES) - rsv_sat;
        res_o.high_water = rsv_sat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q      <= '0;
      row_valid_q <= '0;
      clr_r_q     <= '0;
      free_q      <= CNT_W'(PAGES);
      hwm_q       <= '0;
    end else if (fire) begin
      free_q <= res_o.free_count;
      hwm_q  <= res_o.high_water;
      if (op_q == OP_CLEAR) begin
        row_valid_q <= '0;
        clr_r_q     <= rsv_sat;
        for (int i = 0; i < MAP_WORDS; i++) begin
          full_q[i] <= ({1'b0, rsv_sat} >= ((CNT_W+1)'(i) << 5) + (CNT_W+1)'(32));
        end
      end else if (ram_we) begin
        row_valid_q[word_q] <= 1'b1;
        full_q[word_q]      <= &new_word;
      end
    end
  end

endmodule

/* rtl/core/bitmap_page_allocator.sv */
// Channel   Direction  Contents
// s_axis    in         tuser: opcode; tdata: page address
// m_axis    out        tuser: status; tdata: index, address, counts, grow flag
// cfg       in         register index and 32-bit write data, always ready
//
// Each request is decoded in its accept cycle, then its bitmap RAM word is read,
// then modified and written back. The core takes a new request only after the
// previous result has passed from write-back into the output register.
// The output register frees the core while a result waits; a second result
// holds the core in write-back until the first is taken. Reset is asynchronous;
// per-row valid bits make unwritten map rows read as the last clear pattern.
module bitmap_page_allocator
  import bpa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [31:0] page_address
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]            s_axis_tuser,

  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [9:0] page_num, [41:10] alloc_address, [52:42] free_count,
  // [63:53] high_water, [64] grow_request, upper bits zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]            m_axis_tuser,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ADDR_W-1:0]     cfg_data_i
);

  // Configuration registers. The user must write them only while the block is idle;
  // the block does not enforce this. The control path reads them directly, without shadow copies.
  bpa_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_address   <= '0;
      cfg_q.reserved_pages <= '0;
      cfg_q.grow_threshold <= CNT_W'(1022);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_BASE:      cfg_q.base_address   <= cfg_data_i;
        CFG_RESERVED:  cfg_q.reserved_pages <= cfg_data_i[CNT_W-1:0];
        CFG_THRESHOLD: cfg_q.grow_threshold <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic        res_valid;
  logic        res_ready;
  bpa_result_t res;

  bpa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_o   (s_axis_tready),
    .req_opcode_i  (s_axis_tuser),
    .req_address_i (s_axis_tdata),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // Output register: free, or emptied in this same cycle.
  logic        out_valid_q;
  bpa_result_t out_q;

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {{(OUT_DATA_W - OUT_PAY_W){1'b0}},
                          out_q.grow_request,
                          out_q.high_water,
                          out_q.free_count,
                          out_q.alloc_address,
                          out_q.page_num};

endmodule
